[hw/rtl/dac_spi_frame_writer_defines.svh]
// Assertion macros shared by the DAC SPI frame writer RTL.
`ifndef DAC_SPI_FRAME_WRITER_DEFINES_SVH
`define DAC_SPI_FRAME_WRITER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DSFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dsfw_pkg.sv]
// Shared types and constants for the DAC SPI frame writer.
package dsfw_pkg;

    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned LEVEL_W    = 12;
    localparam int unsigned FRAME_W    = 16;
    localparam int unsigned BIT_CNT_W  = 4;

    localparam logic [HOLD_W-1:0]    HOLD_RESET = 16'd72;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = 4'd15;

    // Pin vector layout: select, clock, data
    typedef logic [2:0] pins_t;
    localparam int unsigned PIN_CS  = 2;
    localparam int unsigned PIN_SCK = 1;
    localparam int unsigned PIN_SDI = 0;

    localparam pins_t PINS_IDLE = 3'b100;

endpackage

[hw/rtl/dac_spi_frame_writer.sv]
// DAC SPI frame writer: builds a 16-bit frame and steps it out as timed pin phases.
//
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | channel, gain_select, output_enable, level
//  m_      | out       | m_valid / m_ready  | cs/sck/sdi for both DACs, last_phase
//  cfg_    | in        | cfg_we             | hold_cycles
//
// One request gives 52 result beats. Each phase passes through the apply state,
// the send state (held there while m_ready is low), then the hold state, where
// the hold counter runs up to max(hold_cycles,1) before the next phase.
// The frame leaves a 16-bit shift register one bit per data phase.
// Reset drives both DACs to select high, clock and data low, and idles.
// A stalled result beat holds the sequencer; no request is taken until the
// frame's last beat is delivered and held.
`include "dac_spi_frame_writer_defines.svh"

module dac_spi_frame_writer (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config
    input  logic                         cfg_we,
    input  logic [dsfw_pkg::HOLD_W-1:0]  cfg_wdata,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_channel,
    input  logic                         s_gain_select,
    input  logic                         s_output_enable,
    input  logic [dsfw_pkg::LEVEL_W-1:0] s_level,
    // phase channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_cs_dac0,
    output logic                         m_sck_dac0,
    output logic                         m_sdi_dac0,
    output logic                         m_cs_dac1,
    output logic                         m_sck_dac1,
    output logic                         m_sdi_dac1,
    output logic                         m_last_phase
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SEND,
        ST_HOLD
    } state_t;

    typedef enum logic [2:0] {
        PH_CS_HI,
        PH_CS_LO,
        PH_SCK_LO,
        PH_DATA,
        PH_SCK_HI,
        PH_SCK_FALL,
        PH_CS_END
    } phase_t;

    state_t                          state_reg, state_next;
    phase_t                          phase_reg, phase_next;
    logic                            m_valid_reg, m_valid_next;
    logic [dsfw_pkg::HOLD_W-1:0]     hold_cycles_reg, hold_cycles_next;
    logic [dsfw_pkg::HOLD_W-1:0]     hold_count_reg, hold_count_next;
    logic [dsfw_pkg::FRAME_W-1:0]    frame_shift_reg, frame_shift_next;
    logic [dsfw_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic                            target_second_reg, target_second_next;
    dsfw_pkg::pins_t                 pins_dac0_reg, pins_dac0_next;
    dsfw_pkg::pins_t                 pins_dac1_reg, pins_dac1_next;

    dsfw_pkg::pins_t                 cur_pins;
    dsfw_pkg::pins_t                 new_pins;
    logic [dsfw_pkg::HOLD_W-1:0]     hold_limit;

    // zero hold is treated as a hold value of one
    assign hold_limit = (hold_cycles_reg == '0) ? dsfw_pkg::HOLD_W'(1) : hold_cycles_reg;
    assign cur_pins   = target_second_reg ? pins_dac1_reg : pins_dac0_reg;

    // Pin levels for the phase being applied
    always_comb begin
        new_pins = cur_pins;
        case (phase_reg)
            PH_CS_HI:    new_pins[dsfw_pkg::PIN_CS]  = 1'b1;
            PH_CS_LO:    new_pins[dsfw_pkg::PIN_CS]  = 1'b0;
            PH_SCK_LO:   new_pins[dsfw_pkg::PIN_SCK] = 1'b0;
            PH_DATA:     new_pins[dsfw_pkg::PIN_SDI] = frame_shift_reg[dsfw_pkg::FRAME_W-1];
            PH_SCK_HI:   new_pins[dsfw_pkg::PIN_SCK] = 1'b1;
            PH_SCK_FALL: new_pins[dsfw_pkg::PIN_SCK] = 1'b0;
            PH_CS_END:   new_pins[dsfw_pkg::PIN_CS]  = 1'b1;
            default:     new_pins = cur_pins;
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        m_valid_next       = m_valid_reg;
        hold_cycles_next   = hold_cycles_reg;
        hold_count_next    = hold_count_reg;
        frame_shift_next   = frame_shift_reg;
        bit_cnt_next       = bit_cnt_reg;
        target_second_next = target_second_reg;
        pins_dac0_next     = pins_dac0_reg;
        pins_dac1_next     = pins_dac1_reg;

        if (cfg_we) begin
            hold_cycles_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    frame_shift_next   = {s_channel[0], 1'b0, s_gain_select,
                                          s_output_enable, s_level};
                    target_second_next = s_channel[1];
                    bit_cnt_next       = '0;
                    phase_next         = PH_CS_HI;
                    state_next         = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (target_second_reg) begin
                    pins_dac1_next = new_pins;
                end else begin
                    pins_dac0_next = new_pins;
                end
                // bit leaves the shift register on its data phase
                if (phase_reg == PH_DATA) begin
                    frame_shift_next = {frame_shift_reg[dsfw_pkg::FRAME_W-2:0], 1'b0};
                end
                m_valid_next = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    m_valid_next    = 1'b0;
                    hold_count_next = dsfw_pkg::HOLD_W'(1);
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (hold_count_reg == hold_limit) begin
                    hold_count_next = '0;
                    state_next      = ST_APPLY;
                    case (phase_reg)
                        PH_CS_HI:    phase_next = PH_CS_LO;
                        PH_CS_LO:    phase_next = PH_SCK_LO;
                        PH_SCK_LO:   phase_next = PH_DATA;
                        PH_DATA:     phase_next = PH_SCK_HI;
                        PH_SCK_HI:   phase_next = PH_SCK_FALL;
                        PH_SCK_FALL: begin
                            if (bit_cnt_reg == dsfw_pkg::LAST_BIT) begin
                                phase_next = PH_CS_END;
                            end else begin
                                bit_cnt_next = bit_cnt_reg + 1'b1;
                                phase_next   = PH_DATA;
                            end
                        end
                        PH_CS_END:   state_next = ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end else begin
                    hold_count_next = hold_count_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_CS_HI;
            m_valid_reg       <= 1'b0;
            hold_cycles_reg   <= dsfw_pkg::HOLD_RESET;
            hold_count_reg    <= '0;
            frame_shift_reg   <= '0;
            bit_cnt_reg       <= '0;
            target_second_reg <= 1'b0;
            pins_dac0_reg     <= dsfw_pkg::PINS_IDLE;
            pins_dac1_reg     <= dsfw_pkg::PINS_IDLE;
        end else begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            m_valid_reg       <= m_valid_next;
            hold_cycles_reg   <= hold_cycles_next;
            hold_count_reg    <= hold_count_next;
            frame_shift_reg   <= frame_shift_next;
            bit_cnt_reg       <= bit_cnt_next;
            target_second_reg <= target_second_next;
            pins_dac0_reg     <= pins_dac0_next;
            pins_dac1_reg     <= pins_dac1_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cs_dac0    = pins_dac0_reg[dsfw_pkg::PIN_CS];
    assign m_sck_dac0   = pins_dac0_reg[dsfw_pkg::PIN_SCK];
    assign m_sdi_dac0   = pins_dac0_reg[dsfw_pkg::PIN_SDI];
    assign m_cs_dac1    = pins_dac1_reg[dsfw_pkg::PIN_CS];
    assign m_sck_dac1   = pins_dac1_reg[dsfw_pkg::PIN_SCK];
    assign m_sdi_dac1   = pins_dac1_reg[dsfw_pkg::PIN_SDI];
    assign m_last_phase = (phase_reg == PH_CS_END);

    // Checks
    `DSFW_ASSERT_NOW(a_idle_no_beat, s_ready, !m_valid_reg, "beat pending while idle")
    `DSFW_ASSERT_NOW(a_last_cs_high, m_valid_reg && m_last_phase, (target_second_reg ? m_cs_dac1 : m_cs_dac0), "last phase without select high")
    `DSFW_ASSERT_NEXT(a_beat_drops, m_valid_reg && m_ready, !m_valid_reg, "valid stays after beat taken")
    `DSFW_ASSERT_NEXT(a_target_load, s_valid && s_ready, target_second_reg == $past(s_channel[1]), "target not loaded from request")
    `DSFW_ASSERT_NEXT(a_other_dac_still, state_reg != ST_IDLE && !target_second_reg, $stable(pins_dac1_reg), "unaddressed DAC pins moved")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the DAC SPI frame writer: random requests, predicted pin phases.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned CYCLE_LIMIT   = 15_000_000;
    localparam int unsigned HOLDOFF_AT    = 3000;   // beat count that starts the long stall
    localparam int unsigned HOLDOFF_LEN   = 2000;
    localparam logic [dsfw_pkg::HOLD_W-1:0] HOLD_ZERO = '0;
    localparam logic [dsfw_pkg::HOLD_W-1:0] HOLD_MIN  = 16'd1;
    localparam logic [dsfw_pkg::HOLD_W-1:0] HOLD_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]                   channel;
        logic                         gain_select;
        logic                         output_enable;
        logic [dsfw_pkg::LEVEL_W-1:0] level;
    } dac_write_t;

    typedef struct packed {
        dsfw_pkg::pins_t dac0;
        dsfw_pkg::pins_t dac1;
        logic            last;
    } pin_phase_t;

    // DUT ports; the inputs are known from time zero
    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_we          = 1'b0;
    logic [dsfw_pkg::HOLD_W-1:0]   cfg_wdata       = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_channel       = '0;
    logic                          s_gain_select   = 1'b0;
    logic                          s_output_enable = 1'b0;
    logic [dsfw_pkg::LEVEL_W-1:0]  s_level         = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic                          m_cs_dac0, m_sck_dac0, m_sdi_dac0;
    logic                          m_cs_dac1, m_sck_dac1, m_sdi_dac1;
    logic                          m_last_phase;

    dac_spi_frame_writer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel       (s_channel),
        .s_gain_select   (s_gain_select),
        .s_output_enable (s_output_enable),
        .s_level         (s_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cs_dac0       (m_cs_dac0),
        .m_sck_dac0      (m_sck_dac0),
        .m_sdi_dac0      (m_sdi_dac0),
        .m_cs_dac1       (m_cs_dac1),
        .m_sck_dac1      (m_sck_dac1),
        .m_sdi_dac1      (m_sdi_dac1),
        .m_last_phase    (m_last_phase)
    );

    // Stimulus and scoreboard state
    dac_write_t                  pending_writes[$];
    pin_phase_t                  pending_phases[$];
    dac_write_t                  offered_write;
    pin_phase_t                  phase_exp;
    dsfw_pkg::pins_t             dac0_pins = dsfw_pkg::PINS_IDLE;
    dsfw_pkg::pins_t             dac1_pins = dsfw_pkg::PINS_IDLE;
    logic [dsfw_pkg::HOLD_W-1:0] hold_now  = dsfw_pkg::HOLD_RESET;
    int unsigned       writes_queued   = 0;
    int unsigned       writes_accepted = 0;
    int unsigned       beats_seen      = 0;
    int unsigned       fail_count      = 0;
    int unsigned       cycle_count     = 0;
    int unsigned       burst_left      = 1;
    int unsigned       gap_left        = 0;
    int unsigned       holdoff_left    = 0;
    bit                holdoff_done    = 1'b0;
    logic [15:0]       ready_pattern   = 16'hFFFF;
    int unsigned       pattern_age     = 0;

    // Clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // --- prediction -------------------------------------------------------

    // Update one pin of the addressed DAC
    function automatic void set_pin(logic second, int unsigned pin, logic val);
        if (second) dac1_pins[pin] = val;
        else        dac0_pins[pin] = val;
    endfunction

    function automatic void push_phase(logic last);
        pending_phases.push_back('{dac0: dac0_pins, dac1: dac1_pins, last: last});
    endfunction

    // Expand one write into its 52 pin phases
    function automatic void expand_frame_phases(dac_write_t w);
        logic [dsfw_pkg::FRAME_W-1:0] frame;
        logic                         second;
        int                           b;
        frame  = {w.channel[0], 1'b0, w.gain_select, w.output_enable, w.level};
        second = w.channel[1];
        // opening: select high only, clock and data keep their levels
        set_pin(second, dsfw_pkg::PIN_CS, 1'b1);
        push_phase(1'b0);
        set_pin(second, dsfw_pkg::PIN_CS, 1'b0);
        push_phase(1'b0);
        set_pin(second, dsfw_pkg::PIN_SCK, 1'b0);
        push_phase(1'b0);
        for (b = dsfw_pkg::FRAME_W - 1; b >= 0; b--) begin
            set_pin(second, dsfw_pkg::PIN_SDI, frame[b]);
            push_phase(1'b0);
            set_pin(second, dsfw_pkg::PIN_SCK, 1'b1);
            push_phase(1'b0);
            set_pin(second, dsfw_pkg::PIN_SCK, 1'b0);
            push_phase(1'b0);
        end
        set_pin(second, dsfw_pkg::PIN_CS, 1'b1);
        push_phase(1'b1);
    endfunction

    // --- request driver ---------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expand_frame_phases(offered_write);
                writes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_writes.size() > 0) begin
                    offered_write = pending_writes.pop_front();
                    s_channel       <= offered_write.channel;
                    s_gain_select   <= offered_write.gain_select;
                    s_output_enable <= offered_write.output_enable;
                    s_level         <= offered_write.level;
                    s_valid         <= 1'b1;
                    // burst done: pick the next gap and burst length
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 4);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // --- phase receiver: pattern stalls plus one long hold-off ------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!holdoff_done && beats_seen >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pattern = 16'hFFFF;
                        1: ready_pattern = 16'($urandom | $urandom);
                        2: ready_pattern = 16'($urandom);
                        default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
                    endcase
                    pattern_age = $urandom_range(50, 400);
                end
                pattern_age--;
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
                m_ready <= ready_pattern[0];
            end
        end
    end

    // --- phase monitor ----------------------------------------------------

    function automatic void check_pin(string name, logic exp_v, logic act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0b, got %0b", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (pending_phases.size() == 0) begin
                $error("phase beat with nothing expected");
                fail_count++;
            end else begin
                phase_exp = pending_phases.pop_front();
                check_pin("cs_dac0",    phase_exp.dac0[dsfw_pkg::PIN_CS],  m_cs_dac0);
                check_pin("sck_dac0",   phase_exp.dac0[dsfw_pkg::PIN_SCK], m_sck_dac0);
                check_pin("sdi_dac0",   phase_exp.dac0[dsfw_pkg::PIN_SDI], m_sdi_dac0);
                check_pin("cs_dac1",    phase_exp.dac1[dsfw_pkg::PIN_CS],  m_cs_dac1);
                check_pin("sck_dac1",   phase_exp.dac1[dsfw_pkg::PIN_SCK], m_sck_dac1);
                check_pin("sdi_dac1",   phase_exp.dac1[dsfw_pkg::PIN_SDI], m_sdi_dac1);
                check_pin("last_phase", phase_exp.last,                    m_last_phase);
            end
        end
    end

    // --- stimulus sequencing ----------------------------------------------

    function automatic void queue_write(logic [1:0] ch, logic g, logic oe,
                                        logic [dsfw_pkg::LEVEL_W-1:0] lvl);
        pending_writes.push_back('{channel: ch, gain_select: g, output_enable: oe, level: lvl});
        writes_queued++;
    endfunction

    function automatic void queue_random_writes(int unsigned n);
        logic [dsfw_pkg::LEVEL_W-1:0] lvl;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0:       lvl = '0;
                1:       lvl = '1;
                default: lvl = dsfw_pkg::LEVEL_W'($urandom_range(0, 4095));
            endcase
            queue_write(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), lvl);
        end
    endfunction

    // Wait until every write is in and every phase is out, then let the
    // last hold finish before touching the register
    task automatic wait_drained();
        do @(posedge aclk);
        while (!(writes_accepted == writes_queued && pending_phases.size() == 0));
        repeat (int'(hold_now) + 8) @(posedge aclk);
    endtask

    task automatic write_hold(logic [dsfw_pkg::HOLD_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        hold_now  = v;
    endtask

    initial begin
        logic [dsfw_pkg::LEVEL_W-1:0] dir_levels [4];
        int                           c, g, oe;
        dir_levels = '{12'h000, 12'hFFF, 12'hAAA, 12'h555};
        wait (aresetn);

        // reset hold time; first frames see the reset pin levels
        queue_write(2'd2, 1'b1, 1'b1, 12'hFFF);
        queue_write(2'd0, 1'b0, 1'b0, 12'h000);
        queue_write(2'd1, 1'b1, 1'b0, 12'h801);
        queue_write(2'd3, 1'b0, 1'b1, 12'h7FE);

        // zero hold time: every channel, gain and enable combination
        write_hold(HOLD_ZERO);
        for (c = 0; c < 4; c++) begin
            for (g = 0; g < 2; g++) begin
                for (oe = 0; oe < 2; oe++) begin
                    queue_write(2'(c), 1'(g), 1'(oe), dir_levels[(c + g + oe) % 4]);
                end
            end
        end

        // shortest nonzero hold; the long receiver hold-off lands here
        write_hold(HOLD_MIN);
        queue_random_writes(40);

        write_hold(dsfw_pkg::HOLD_W'($urandom_range(2, 9)));
        queue_random_writes(40);

        // longest hold, one frame only
        write_hold(HOLD_MAX);
        queue_write(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)),
                    dsfw_pkg::LEVEL_W'($urandom_range(0, 4095)));

        write_hold(16'd3);
        queue_random_writes(10);

        wait_drained();
        $display("Ran %0d DAC writes (%0d pin phases) across all channels,", writes_accepted,
                 beats_seen);
        $display("hold times 72, 0, 1, small random, 65535 and 3, with input and output stalls.");
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
